[hdl/rmq_pkg.sv]
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies; every other file in hdl/ imports this package.
package rmq_pkg;

  localparam int unsigned DataWidthDefault = 16;
  localparam int unsigned FifoDepthDefault = 2;
  localparam int unsigned NumLanes         = 3;

  // Which Shepperd branch a matrix takes.
  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_M00   = 2'd1,
    BR_M11   = 2'd2,
    BR_M22   = 2'd3
  } branch_e;

endpackage

[hdl/rotation_matrix_to_quaternion.sv]
// Rotation matrix to unit quaternion (Shepperd trace-branch method), all
// values signed Q2.(DataWidth-2). Top level; uses rmq_pkg, rmq_front,
// rmq_fifo and rmq_back.
//
// Takes one 3x3 matrix per request and returns one quaternion (w, x, y, z)
// plus the branch that produced it. A positive trace gives S = 2*sqrt(t+1);
// otherwise the largest diagonal entry (strictly greater, ties falling to
// the later entry) picks the branch. A negative radicand clamps to zero, a
// zero S yields zero components, and the three quotients saturate. The
// block accepts one matrix every clock cycle when the output side keeps
// up. A matrix passes through the front register, the queue, DataWidth
// stages of the square root and 2*DataWidth-1 stages of the divider, one
// digit each, and the output register. The front end and the back end
// stall independently; a small queue between them absorbs the difference.
// No reset-time clearing is needed and nothing is configured.
module rotation_matrix_to_quaternion #(
  parameter int unsigned DataWidth = rmq_pkg::DataWidthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [DataWidth-1:0] m00_i,
  input  logic signed [DataWidth-1:0] m01_i,
  input  logic signed [DataWidth-1:0] m02_i,
  input  logic signed [DataWidth-1:0] m10_i,
  input  logic signed [DataWidth-1:0] m11_i,
  input  logic signed [DataWidth-1:0] m12_i,
  input  logic signed [DataWidth-1:0] m20_i,
  input  logic signed [DataWidth-1:0] m21_i,
  input  logic signed [DataWidth-1:0] m22_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DataWidth-1:0] quat_w_o,
  output logic signed [DataWidth-1:0] quat_x_o,
  output logic signed [DataWidth-1:0] quat_y_o,
  output logic signed [DataWidth-1:0] quat_z_o,
  output logic [1:0]                  branch_taken_o
);
  import rmq_pkg::*;

  localparam int unsigned MW    = DataWidth + 1;
  localparam int unsigned ItemW = 2 + MW + 3 + 3 * MW;

  logic signed [DataWidth-1:0] m [9];
  logic                        front_vld, front_rdy;
  logic [ItemW-1:0]            front_item;
  logic                        q_vld, back_rdy;
  logic [ItemW-1:0]            q_item;
  logic [DataWidth-1:0]        quat [4];
  branch_e                     br;

  assign m = '{m00_i, m01_i, m02_i, m10_i, m11_i, m12_i, m20_i, m21_i, m22_i};

  // Front: classify the matrix and form radicand and numerators.
  rmq_front #(.W(DataWidth)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .m_i          (m),
    .item_valid_o (front_vld),
    .item_ready_i (front_rdy),
    .item_o       (front_item)
  );

  // Hold classified requests while the back end stalls.
  rmq_fifo #(.DataW(ItemW), .Depth(FifoDepthDefault)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_vld),
    .push_ready_o (front_rdy),
    .push_data_i  (front_item),
    .pop_valid_o  (q_vld),
    .pop_ready_i  (back_rdy),
    .pop_data_o   (q_item)
  );

  // Back: square root, divisions, saturation, output register.
  rmq_back #(.W(DataWidth)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_vld),
    .item_ready_o (back_rdy),
    .item_i       (q_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .quat_o       (quat),
    .branch_o     (br)
  );

  assign quat_w_o       = quat[0];
  assign quat_x_o       = quat[1];
  assign quat_y_o       = quat[2];
  assign quat_z_o       = quat[3];
  assign branch_taken_o = br;

`ifndef SYNTHESIS
  // A full queue must push back on the front register.
  a_front_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_vld && !front_rdy |-> !in_ready_o)
    else $error("front accepted while queue full");

  // A stalled output must freeze the back pipeline.
  a_back_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !back_rdy)
    else $error("back end advanced during output stall");

  // On the trace branch w is S/4 and never negative.
  a_trace_w_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (branch_taken_o == BR_TRACE) |-> !quat_w_o[DataWidth-1])
    else $error("negative w on trace branch");
`endif

endmodule

[hdl/rmq_front.sv]
// Front end: registers one matrix, picks the branch, forms the radicand and
// the three off-diagonal numerators as sign and magnitude. Uses rmq_pkg.
module rmq_front #(
  parameter int unsigned W = rmq_pkg::DataWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [W-1:0] m_i [9],
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output logic [2+(W+1)+3+3*(W+1)-1:0] item_o
);
  import rmq_pkg::*;

  localparam int unsigned MW    = W + 1;
  localparam int unsigned TW    = W + 2;
  localparam int unsigned ItemW = 2 + MW + 3 + 3 * MW;
  localparam logic signed [TW-1:0] One = {{(TW-W+1){1'b0}}, 1'b1, {(W-2){1'b0}}};

  logic signed [TW-1:0] e [9];
  logic signed [TW-1:0] tr, dsum, rad_s;
  logic [MW-1:0]        rad;
  logic signed [MW-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
  logic signed [MW-1:0] n [NumLanes];
  logic [MW-1:0]        mag [NumLanes];
  logic [2:0]           neg;
  branch_e              br;
  logic                 vld_q;
  logic [ItemW-1:0]     item_q;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e[i] = $signed({{2{m_i[i][W-1]}}, m_i[i]});
    end
    tr = e[0] + e[4] + e[8];
    if (tr > 0) begin
      br = BR_TRACE;
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      br = BR_M00;
    end else if (e[4] > e[8]) begin
      br = BR_M11;
    end else begin
      br = BR_M22;
    end
    case (br)
      BR_TRACE: dsum = tr;
      BR_M00:   dsum = e[0] - e[4] - e[8];
      BR_M11:   dsum = e[4] - e[0] - e[8];
      BR_M22:   dsum = e[8] - e[0] - e[4];
      default:  dsum = tr;
    endcase
    rad_s = One + dsum;
    // Clamp a negative radicand to zero.
    rad = rad_s[TW-1] ? '0 : rad_s[MW-1:0];

    d21_12 = $signed(e[7][MW-1:0]) - $signed(e[5][MW-1:0]);
    d02_20 = $signed(e[2][MW-1:0]) - $signed(e[6][MW-1:0]);
    d10_01 = $signed(e[3][MW-1:0]) - $signed(e[1][MW-1:0]);
    s01_10 = $signed(e[1][MW-1:0]) + $signed(e[3][MW-1:0]);
    s02_20 = $signed(e[2][MW-1:0]) + $signed(e[6][MW-1:0]);
    s12_21 = $signed(e[5][MW-1:0]) + $signed(e[7][MW-1:0]);

    // Numerators of the three non-diagonal components, in w, x, y, z order.
    case (br)
      BR_TRACE: begin n[0] = d21_12; n[1] = d02_20; n[2] = d10_01; end
      BR_M00:   begin n[0] = d21_12; n[1] = s01_10; n[2] = s02_20; end
      BR_M11:   begin n[0] = d02_20; n[1] = s01_10; n[2] = s12_21; end
      BR_M22:   begin n[0] = d10_01; n[1] = s02_20; n[2] = s12_21; end
      default:  begin n[0] = d21_12; n[1] = d02_20; n[2] = d10_01; end
    endcase
    for (int l = 0; l < NumLanes; l++) begin
      neg[l] = n[l][MW-1];
      mag[l] = neg[l] ? MW'(-n[l]) : MW'(n[l]);
    end
  end

  assign in_ready_o   = !vld_q || item_ready_i;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= {br, rad, neg, mag[0], mag[1], mag[2]};
    end
  end

endmodule

[hdl/rmq_fifo.sv]
// Short register queue between the front end and the back end.
// Uses rmq_pkg for its default depth.
module rmq_fifo #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = rmq_pkg::FifoDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [DataW-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [DataW-1:0] pop_data_o
);
  import rmq_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

[hdl/rmq_sqrt.sv]
// Pipelined integer square root, one result bit per stage, with a sideband
// that travels alongside. Uses rmq_pkg.
module rmq_sqrt #(
  parameter int unsigned N   = rmq_pkg::DataWidthDefault,
  parameter int unsigned SbW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [2*N-1:0]   x_i,
  input  logic [SbW-1:0]   sb_i,
  output logic             valid_o,
  output logic [N-1:0]     root_o,
  output logic [SbW-1:0]   sb_o
);
  import rmq_pkg::*;

  localparam int unsigned RemW = N + 3;

  logic             vld_q  [N];
  logic [2*N-1:0]   x_q    [N];
  logic [RemW-1:0]  rem_q  [N];
  logic [N-1:0]     root_q [N];
  logic [SbW-1:0]   sb_q   [N];

  logic             vld_in  [N];
  logic [2*N-1:0]   x_in    [N];
  logic [RemW-1:0]  rem_in  [N];
  logic [N-1:0]     root_in [N];
  logic [SbW-1:0]   sb_in   [N];
  logic [RemW-1:0]  rem_t   [N];
  logic [RemW-1:0]  trial   [N];
  logic [RemW-1:0]  rem_d   [N];
  logic [N-1:0]     root_d  [N];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        vld_in[k]  = valid_i;
        x_in[k]    = x_i;
        rem_in[k]  = '0;
        root_in[k] = '0;
        sb_in[k]   = sb_i;
      end else begin
        vld_in[k]  = vld_q[k-1];
        x_in[k]    = x_q[k-1];
        rem_in[k]  = rem_q[k-1];
        root_in[k] = root_q[k-1];
        sb_in[k]   = sb_q[k-1];
      end
      rem_t[k] = {rem_in[k][RemW-3:0], x_in[k][2*N-1:2*N-2]};
      trial[k] = {1'b0, root_in[k], 2'b01};
      if (rem_t[k] >= trial[k]) begin
        rem_d[k]  = rem_t[k] - trial[k];
        root_d[k] = {root_in[k][N-2:0], 1'b1};
      end else begin
        rem_d[k]  = rem_t[k];
        root_d[k] = {root_in[k][N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      for (int k = 0; k < N; k++) begin
        vld_q[k] <= vld_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        x_q[k]    <= {x_in[k][2*N-3:0], 2'b00};
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        sb_q[k]   <= sb_in[k];
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign sb_o    = sb_q[N-1];

endmodule

[hdl/rmq_div.sv]
// Pipelined restoring divider, one quotient bit per stage, three lanes that
// share one divisor, plus a sideband. Uses rmq_pkg.
module rmq_div #(
  parameter int unsigned W   = rmq_pkg::DataWidthDefault,
  parameter int unsigned SbW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [W:0]          div_i,
  input  logic [2*W-2:0]      dd_i [rmq_pkg::NumLanes],
  input  logic [SbW-1:0]      sb_i,
  output logic                valid_o,
  output logic [W:0]          div_o,
  output logic [2*W-2:0]      q_o  [rmq_pkg::NumLanes],
  output logic [SbW-1:0]      sb_o
);
  import rmq_pkg::*;

  localparam int unsigned DdW  = 2 * W - 1;
  localparam int unsigned DvW  = W + 1;
  localparam int unsigned RemW = W + 2;

  logic             vld_q [DdW];
  logic [DvW-1:0]   div_q [DdW];
  logic [SbW-1:0]   sb_q  [DdW];
  logic [DdW-1:0]   dd_q  [DdW][NumLanes];
  logic [DdW-1:0]   qt_q  [DdW][NumLanes];
  logic [RemW-1:0]  rem_q [DdW][NumLanes];

  logic             vld_in [DdW];
  logic [DvW-1:0]   div_in [DdW];
  logic [SbW-1:0]   sb_in  [DdW];
  logic [DdW-1:0]   dd_in  [DdW][NumLanes];
  logic [DdW-1:0]   qt_in  [DdW][NumLanes];
  logic [RemW-1:0]  rem_in [DdW][NumLanes];
  logic [RemW-1:0]  rem_t  [DdW][NumLanes];
  logic [RemW-1:0]  rem_d  [DdW][NumLanes];
  logic             ge     [DdW][NumLanes];

  always_comb begin
    for (int k = 0; k < DdW; k++) begin
      if (k == 0) begin
        vld_in[k] = valid_i;
        div_in[k] = div_i;
        sb_in[k]  = sb_i;
      end else begin
        vld_in[k] = vld_q[k-1];
        div_in[k] = div_q[k-1];
        sb_in[k]  = sb_q[k-1];
      end
      for (int l = 0; l < NumLanes; l++) begin
        if (k == 0) begin
          dd_in[k][l]  = dd_i[l];
          qt_in[k][l]  = '0;
          rem_in[k][l] = '0;
        end else begin
          dd_in[k][l]  = dd_q[k-1][l];
          qt_in[k][l]  = qt_q[k-1][l];
          rem_in[k][l] = rem_q[k-1][l];
        end
        rem_t[k][l] = {rem_in[k][l][RemW-2:0], dd_in[k][l][DdW-1]};
        ge[k][l]    = (rem_t[k][l] >= {1'b0, div_in[k]});
        rem_d[k][l] = ge[k][l] ? rem_t[k][l] - {1'b0, div_in[k]} : rem_t[k][l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DdW; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      for (int k = 0; k < DdW; k++) begin
        vld_q[k] <= vld_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DdW; k++) begin
        div_q[k] <= div_in[k];
        sb_q[k]  <= sb_in[k];
        for (int l = 0; l < NumLanes; l++) begin
          dd_q[k][l]  <= {dd_in[k][l][DdW-2:0], 1'b0};
          qt_q[k][l]  <= {qt_in[k][l][DdW-2:0], ge[k][l]};
          rem_q[k][l] <= rem_d[k][l];
        end
      end
    end
  end

  assign valid_o = vld_q[DdW-1];
  assign div_o   = div_q[DdW-1];
  assign sb_o    = sb_q[DdW-1];
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      q_o[l] = qt_q[DdW-1][l];
    end
  end

endmodule

[hdl/rmq_back.sv]
// Back end: square root, three divisions by S, saturation and the output
// register. Uses rmq_pkg, rmq_sqrt and rmq_div.
module rmq_back #(
  parameter int unsigned W = rmq_pkg::DataWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  logic [2+(W+1)+3+3*(W+1)-1:0] item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [W-1:0]        quat_o [4],
  output rmq_pkg::branch_e    branch_o
);
  import rmq_pkg::*;

  localparam int unsigned MW   = W + 1;
  localparam int unsigned DdW  = 2 * W - 1;
  localparam int unsigned SqSb = 2 + 3 + 3 * MW;
  localparam int unsigned DvSb = 2 + 3 + (W - 1);
  localparam logic [DdW-1:0] QMax   = {{(DdW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [DdW-1:0] MinMag = {{(DdW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  logic                en;
  logic [1:0]          in_br;
  logic [MW-1:0]       in_rad;
  logic [SqSb-1:0]     sq_sb_in, sq_sb;
  logic                sq_vld;
  logic [W-1:0]        root;
  logic [MW-1:0]       sq_mag [NumLanes];
  logic [2:0]          sq_neg;
  logic [1:0]          sq_br;
  logic [DdW-1:0]      dd [NumLanes];
  logic [DvSb-1:0]     dv_sb;
  logic                dv_vld;
  logic [MW-1:0]       dv_div;
  logic [DdW-1:0]      qt [NumLanes];
  logic [W-1:0]        sat [NumLanes];
  logic [W-1:0]        diag;
  logic [W-1:0]        comp [4];
  branch_e             dv_br;
  logic [2:0]          dv_neg;
  logic                out_vld_q;
  logic [W-1:0]        quat_q [4];
  branch_e             br_q;

  // Advance the whole back pipeline whenever the output register can load.
  assign en           = !out_vld_q || out_ready_i;
  assign item_ready_o = en;

  assign in_br    = item_i[2+MW+3+3*MW-1 -: 2];
  assign in_rad   = item_i[MW+3+3*MW-1 -: MW];
  assign sq_sb_in = {in_br, item_i[3+3*MW-1:0]};

  rmq_sqrt #(.N(W), .SbW(SqSb)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (item_valid_i),
    .x_i     ({1'b0, in_rad, {(W-2){1'b0}}}),
    .sb_i    (sq_sb_in),
    .valid_o (sq_vld),
    .root_o  (root),
    .sb_o    (sq_sb)
  );

  assign sq_br     = sq_sb[SqSb-1 -: 2];
  assign sq_neg    = sq_sb[3+3*MW-1 -: 3];
  assign sq_mag[0] = sq_sb[3*MW-1 -: MW];
  assign sq_mag[1] = sq_sb[2*MW-1 -: MW];
  assign sq_mag[2] = sq_sb[MW-1:0];

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      dd[l] = {sq_mag[l], {(W-2){1'b0}}};
    end
  end

  rmq_div #(.W(W), .SbW(DvSb)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .div_i   ({root, 1'b0}),
    .dd_i    (dd),
    .sb_i    ({sq_br, sq_neg, root[W-1:1]}),
    .valid_o (dv_vld),
    .div_o   (dv_div),
    .q_o     (qt),
    .sb_o    (dv_sb)
  );

  assign dv_br  = branch_e'(dv_sb[DvSb-1 -: 2]);
  assign dv_neg = dv_sb[W+1 -: 3];
  // S/4 = root/2 stays below the positive limit, so no saturation is needed.
  assign diag   = {1'b0, dv_sb[W-2:0]};

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      if (dv_div == '0) begin
        sat[l] = '0;
      end else if (dv_neg[l]) begin
        sat[l] = (qt[l] > MinMag) ? MinMag[W-1:0] : W'(-qt[l][W-1:0]);
      end else begin
        sat[l] = (qt[l] > QMax) ? QMax[W-1:0] : qt[l][W-1:0];
      end
    end
    case (dv_br)
      BR_TRACE: begin comp[0] = diag;   comp[1] = sat[0]; comp[2] = sat[1]; comp[3] = sat[2]; end
      BR_M00:   begin comp[0] = sat[0]; comp[1] = diag;   comp[2] = sat[1]; comp[3] = sat[2]; end
      BR_M11:   begin comp[0] = sat[0]; comp[1] = sat[1]; comp[2] = diag;   comp[3] = sat[2]; end
      BR_M22:   begin comp[0] = sat[0]; comp[1] = sat[1]; comp[2] = sat[2]; comp[3] = diag;   end
      default:  begin comp[0] = diag;   comp[1] = sat[0]; comp[2] = sat[1]; comp[3] = sat[2]; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      quat_q <= comp;
      br_q   <= dv_br;
    end
  end

  assign out_valid_o = out_vld_q;
  assign quat_o      = quat_q;
  assign branch_o    = br_q;

endmodule

[tb/tb_rotation_matrix_to_quaternion.sv]
// Testbench for rotation_matrix_to_quaternion: drives matrices, predicts each
// quaternion and branch, and compares every result in order.
// Depends on rmq_pkg and the block's RTL in hdl/.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
  import rmq_pkg::*;

  localparam int DW = 16;
  localparam int FB = DW - 2;
  localparam int LATENCY = 3 * DW + 2;
  localparam longint QMAX = (64'sd1 <<< (DW - 1)) - 1;
  localparam longint QMIN = -(64'sd1 <<< (DW - 1));
  localparam longint CYCLE_LIMIT = 600000;

  typedef logic signed [DW-1:0] q_t;

  typedef struct packed {
    q_t w, x, y, z;
    branch_e br;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  q_t m00_i = '0, m01_i = '0, m02_i = '0;
  q_t m10_i = '0, m11_i = '0, m12_i = '0;
  q_t m20_i = '0, m21_i = '0, m22_i = '0;
  logic in_ready_o, out_valid_o;
  q_t quat_w_o, quat_x_o, quat_y_o, quat_z_o;
  logic [1:0] branch_taken_o;

  quat_t expected_quats[$];
  int mismatches = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 1'b0;

  rotation_matrix_to_quaternion #(.DataWidth(DW)) uut (.*);

  always #2 clk_i = ~clk_i;

  // Count cycles and end the run if it hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Bitwise integer square root, floor.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Quotient n/s in fixed point, truncated toward zero and saturated.
  function automatic q_t fixed_div(longint n, longint unsigned s);
    longint unsigned mag, q;
    if (s == 0) return '0;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    q = (mag << FB) / s;
    if (n < 0) begin
      if (q > longint'(-QMIN)) return q_t'(QMIN);
      return q_t'(-longint'(q));
    end
    if (q > QMAX) return q_t'(QMAX);
    return q_t'(q);
  endfunction

  function automatic quat_t predict_quat(q_t a[9]);
    longint e[9];
    longint tr, rad, diag;
    longint unsigned s;
    quat_t r;
    foreach (a[i]) e[i] = longint'(a[i]);
    tr = e[0] + e[4] + e[8];
    if (tr > 0) begin
      r.br = BR_TRACE; rad = (64'sd1 <<< FB) + tr;
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      r.br = BR_M00; rad = (64'sd1 <<< FB) + e[0] - e[4] - e[8];
    end else if (e[4] > e[8]) begin
      r.br = BR_M11; rad = (64'sd1 <<< FB) + e[4] - e[0] - e[8];
    end else begin
      r.br = BR_M22; rad = (64'sd1 <<< FB) + e[8] - e[0] - e[4];
    end
    if (rad < 0) rad = 0;
    s = int_sqrt(longint'(rad) << FB) * 2;
    diag = longint'(s >> 2);
    if (diag > QMAX) diag = QMAX;
    case (r.br)
      BR_TRACE: begin
        r.w = q_t'(diag);
        r.x = fixed_div(e[7] - e[5], s);
        r.y = fixed_div(e[2] - e[6], s);
        r.z = fixed_div(e[3] - e[1], s);
      end
      BR_M00: begin
        r.w = fixed_div(e[7] - e[5], s);
        r.x = q_t'(diag);
        r.y = fixed_div(e[1] + e[3], s);
        r.z = fixed_div(e[2] + e[6], s);
      end
      BR_M11: begin
        r.w = fixed_div(e[2] - e[6], s);
        r.x = fixed_div(e[1] + e[3], s);
        r.y = q_t'(diag);
        r.z = fixed_div(e[5] + e[7], s);
      end
      default: begin
        r.w = fixed_div(e[3] - e[1], s);
        r.x = fixed_div(e[2] + e[6], s);
        r.y = fixed_div(e[5] + e[7], s);
        r.z = q_t'(diag);
      end
    endcase
    return r;
  endfunction

  // Offer one request and wait until it is accepted. Valid stays high on
  // return; the next call replaces the payload or drops valid while idling,
  // and wait_drained drops it at the end of a burst.
  task automatic send_matrix(q_t a[9]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {m00_i, m01_i, m02_i, m10_i, m11_i, m12_i, m20_i, m21_i, m22_i} <=
        {a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8]};
    expected_quats.push_back(predict_quat(a));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drive out_ready; a hold stalls the receiver completely.
  always @(posedge clk_i) begin
    if (!rst_ni || recv_hold) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    quat_t exp_q;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        exp_q = expected_quats.pop_front();
        if (exp_q.w !== quat_w_o || exp_q.x !== quat_x_o || exp_q.y !== quat_y_o
            || exp_q.z !== quat_z_o || exp_q.br !== branch_taken_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp w%0d x%0d y%0d z%0d br%0d got w%0d x%0d y%0d z%0d br%0d",
                     exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.br,
                     quat_w_o, quat_x_o, quat_y_o, quat_z_o, branch_taken_o);
        end
      end
    end
  end

  function automatic q_t rand_entry();
    case ($urandom_range(5))
      0: return q_t'($urandom);
      1: return q_t'(QMAX);
      2: return q_t'(QMIN);
      3: return q_t'($urandom_range(32767) >> $urandom_range(14));
      default: return q_t'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  // Random matrices; a diagonal entry is sometimes raised to favor its branch.
  task automatic send_random(int n);
    q_t a[9];
    repeat (n) begin
      if ($urandom_range(3) == 0) begin
        foreach (a[i]) a[i] = rand_entry();
      end else begin
        foreach (a[i]) a[i] = q_t'(int'($urandom_range(32768)) - 16384);
        if ($urandom_range(1)) a[$urandom_range(2) * 4] = q_t'($urandom_range(16384));
        if ($urandom_range(7) == 0) a[$urandom_range(8)] = a[$urandom_range(8)];
      end
      send_matrix(a);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    q_t one, a[9];
    one = q_t'(1 << FB);
    a = '{one, 0, 0, 0, one, 0, 0, 0, one};                 send_matrix(a);
    a = '{one, 0, 0, 0, -one, 0, 0, 0, -one};               send_matrix(a);
    a = '{-one, 0, 0, 0, one, 0, 0, 0, -one};               send_matrix(a);
    a = '{-one, 0, 0, 0, -one, 0, 0, 0, one};               send_matrix(a);
    // Ties on the diagonal fall through to later branches.
    a = '{0, 100, 200, 300, 0, 400, 500, 600, 0};           send_matrix(a);
    a = '{-5, 7, 9, 11, -5, 13, 15, 17, -9};                send_matrix(a);
    // Negative trace with equal diagonals; both take the last branch.
    a = '{q_t'(QMIN), 5, 6, 7, q_t'(QMIN), 8, 9, 10, q_t'(QMIN)}; send_matrix(a);
    a = '{-one, 1, 2, 3, -one, 4, 5, 6, -one};              send_matrix(a);
    // Saturation of large quotients.
    a = '{q_t'(QMAX), q_t'(QMIN), q_t'(QMAX), q_t'(QMAX), q_t'(QMAX),
          q_t'(QMIN), q_t'(QMIN), q_t'(QMAX), q_t'(QMAX)};   send_matrix(a);
    a = '{1, q_t'(QMAX), q_t'(QMIN), q_t'(QMIN), 0, q_t'(QMAX),
          q_t'(QMAX), q_t'(QMIN), 0};                        send_matrix(a);
    a = '{q_t'(QMIN), q_t'(QMAX), q_t'(QMAX), q_t'(QMAX), q_t'(QMIN),
          q_t'(QMAX), q_t'(QMAX), q_t'(QMAX), q_t'(QMAX)};   send_matrix(a);
    a = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};              send_matrix(a);
    a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                       send_matrix(a);
    wait_drained();
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(500);
    send_idle_pct = 78; recv_stall_pct = 0;  send_random(300);
    send_idle_pct = 0;  recv_stall_pct = 78; send_random(300);
    send_idle_pct = 9;  recv_stall_pct = 9;  send_random(300);
    send_idle_pct = 0;  recv_stall_pct = 0;
  endtask

  // Hold the receiver off so the pipeline fills and stalls its input.
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      send_random(250);
    join
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_idle_phases();
    test_backpressure();
    wait_drained();
    repeat (2 * LATENCY) @(posedge clk_i);
    if (mismatches == 0 && expected_quats.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
